/* hdl/tkl_pkg.sv */
// Shared types and constants for the tensor KL nearest-center block.
// No dependencies.
`timescale 1ns / 1ps

package tkl_pkg;

    localparam int CENTERS_DEF = 8;
    localparam int SCALES_DEF  = 4;
    localparam int CENTER_W    = 3;
    localparam int SCALE_W     = 2;
    localparam int SUM_W       = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
    localparam int ACT_W       = 4;
    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

    localparam logic REQ_LOAD     = 1'b0;
    localparam logic REQ_CLASSIFY = 1'b1;

    localparam logic [1:0] ELEM_A = 2'd0;
    localparam logic [1:0] ELEM_B = 2'd1;
    localparam logic [1:0] ELEM_C = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic       capture;     // latch the request
        logic       store_we;    // write element of a load
        logic [1:0] store_elem;  // element being read or written
        logic       store_rd;    // issue read of current center
        logic       prod_s1;     // first multiply step
        logic       prod_s2;     // second multiply step
        logic       det_s;       // form det1 (first pass)
        logic       div_start;   // launch both divisions
        logic       accum;       // fold term into sum
        logic       pick_init;   // start min search
        logic       pick_step;   // compare one sum
        logic       emit;        // present result
        logic       clear_step;  // zero one sum
    } tkl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_done;
    } tkl_sts_t;

endpackage

/* hdl/tkl_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module tkl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

/* hdl/tkl_div.sv */
// Radix-2 restoring divider: 30-bit integer part check plus 16 fraction bits.
// Uses tkl_pkg; one quotient bit per cycle.
`timescale 1ns / 1ps

module tkl_div
    import tkl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [48:0] num,   // magnitude
    input  logic [47:0] den,   // magnitude, nonzero
    output logic        done,
    output logic        ovf,
    output logic [45:0] quo    // Q30.16 magnitude
);

    // quotient of (num << 16) / den; integer part overflow when >= 2^46 total
    localparam int QW = 65;
    logic [64:0] dvd_reg, dvd_next;
    logic [48:0] rem_reg, rem_next;
    logic [64:0] q_reg, q_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [47:0] den_reg, den_next;
    logic [49:0] trial;

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        den_next  = den_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[QW-1]} - {2'b00, den_reg};
        if (start)
        begin
            dvd_next  = {num, 16'd0};
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = 7'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[QW-2:0], 1'b0};
            if (!trial[49])
            begin
                rem_next = trial[48:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[47:0], dvd_reg[QW-1]};
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign ovf  = |q_reg[64:46];
    assign quo  = q_reg[45:0];

endmodule

/* hdl/tkl_datapath.sv */
// Datapath: center store, products, determinants, two dividers, sums, min search.
// Uses tkl_pkg, tkl_ram, tkl_div.
`timescale 1ns / 1ps

module tkl_datapath
    import tkl_pkg::*;
#(
    parameter int CENTERS = CENTERS_DEF,
    parameter int SCALES  = SCALES_DEF,
    localparam int CIDX_W = (CENTERS > 1) ? $clog2(CENTERS) : 1,
    localparam int DEPTH  = CENTERS * SCALES * 3,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tkl_cmd_t           cmd,
    output tkl_sts_t           sts,
    input  logic [CIDX_W-1:0]  cur_center,
    input  logic               in_range,
    input  logic [CENTER_W-1:0] center_sel,
    input  logic [SCALE_W-1:0] scale_sel,
    input  logic signed [31:0] tensor_a,
    input  logic signed [31:0] tensor_b,
    input  logic signed [31:0] tensor_c,
    output logic [CENTER_W-1:0] best_center,
    output logic [SUM_W-1:0]   best_distance,
    output logic               degenerate,
    output logic               result_strobe
);

    logic [CENTER_W-1:0] csel_reg;
    logic [SCALE_W-1:0]  ssel_reg;
    logic signed [31:0]  a1_reg, b1_reg, c1_reg;
    logic signed [31:0]  a2_reg, b2_reg, c2_reg;

    // store address: (center*SCALES + scale)*3 + elem
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W+7:0] addr_wide;
    logic [31:0]       wdata, rdata;
    logic [CENTER_W+CIDX_W-1:0] ctr_mux;

    always_comb
    begin
        ctr_mux = cmd.store_we ? (CENTER_W+CIDX_W)'(csel_reg)
                               : (CENTER_W+CIDX_W)'(cur_center);
        addr_wide = ((ADDR_W+8)'(ctr_mux) * (ADDR_W+8)'(SCALES)
                     + (ADDR_W+8)'(ssel_reg)) * (ADDR_W+8)'(3)
                     + (ADDR_W+8)'(cmd.store_elem);
        addr = addr_wide[ADDR_W-1:0];
        case (cmd.store_elem)
            ELEM_A:  wdata = a1_reg;
            ELEM_B:  wdata = b1_reg;
            default: wdata = c1_reg;
        endcase
    end

    tkl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .clk  (clk),
        .we   (cmd.store_we),
        .addr (addr),
        .wdata(wdata),
        .rdata(rdata)
    );

    // read data arrives in the cycle after store_rd
    logic       rd_d_reg;
    logic [1:0] rd_elem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_d_reg <= 1'b0;
        end
        else
        begin
            rd_d_reg <= cmd.store_rd;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_elem_reg <= cmd.store_elem;
        if (cmd.capture)
        begin
            csel_reg <= center_sel;
            ssel_reg <= scale_sel;
            a1_reg   <= tensor_a;
            b1_reg   <= tensor_b;
            c1_reg   <= tensor_c;
        end
        if (rd_d_reg)
        begin
            case (rd_elem_reg)
                ELEM_A:  a2_reg <= rdata;
                ELEM_B:  b2_reg <= rdata;
                default: c2_reg <= rdata;
            endcase
        end
    end

    // step 1: a1*b2, b1*a2, c1*c2; step 2: a2*b2, c2*c2; det1 step: a1*b1, c1*c1
    logic signed [63:0] p0_reg, p1_reg, p2_reg;
    logic signed [63:0] m0, m1, m2;
    logic signed [31:0] x0, y0, x1, y1, x2, y2;

    always_comb
    begin
        if (cmd.prod_s1)
        begin
            x0 = a1_reg; y0 = b2_reg;
            x1 = b1_reg; y1 = a2_reg;
            x2 = c1_reg; y2 = c2_reg;
        end
        else if (cmd.det_s)
        begin
            x0 = a1_reg; y0 = b1_reg;
            x1 = c1_reg; y1 = c1_reg;
            x2 = 32'sd0; y2 = 32'sd0;
        end
        else
        begin
            x0 = a2_reg; y0 = b2_reg;
            x1 = c2_reg; y1 = c2_reg;
            x2 = 32'sd0; y2 = 32'sd0;
        end
        m0 = x0 * y0;
        m1 = x1 * y1;
        m2 = x2 * y2;
    end

    logic signed [48:0] num_reg, det1_reg, det2_reg;
    logic signed [48:0] diff;

    // floor shift by 16 is arithmetic shift
    assign diff = 49'(p0_reg >>> 16) - 49'(p1_reg >>> 16);

    logic prod_s1_d_reg, prod_s2_d_reg, det_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_s1_d_reg <= 1'b0;
            prod_s2_d_reg <= 1'b0;
            det_d_reg     <= 1'b0;
        end
        else
        begin
            prod_s1_d_reg <= cmd.prod_s1;
            prod_s2_d_reg <= cmd.prod_s2;
            det_d_reg     <= cmd.det_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prod_s1 || cmd.prod_s2 || cmd.det_s)
        begin
            p0_reg <= m0;
            p1_reg <= m1;
            p2_reg <= m2;
        end
        if (prod_s1_d_reg)
        begin
            num_reg <= 49'(p0_reg >>> 16) + 49'(p1_reg >>> 16)
                       - 49'((p2_reg >>> 16) <<< 1);
        end
        if (prod_s2_d_reg)
        begin
            det2_reg <= diff;
        end
        if (det_d_reg)
        begin
            det1_reg <= diff;
        end
    end

    logic [48:0] num_mag;
    logic [47:0] d1_mag, d2_mag;
    logic        q1_done, q2_done, q1_ovf, q2_ovf;
    logic [45:0] q1, q2;
    logic signed [48:0] d1_abs, d2_abs;

    assign num_mag = num_reg[48] ? 49'(-num_reg) : num_reg;
    assign d1_abs  = det1_reg[48] ? -det1_reg : det1_reg;
    assign d2_abs  = det2_reg[48] ? -det2_reg : det2_reg;
    assign d1_mag  = d1_abs[47:0];
    assign d2_mag  = d2_abs[47:0];

    tkl_div u_div1 (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(num_mag), .den(d1_mag), .done(q1_done), .ovf(q1_ovf), .quo(q1)
    );

    tkl_div u_div2 (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .num(num_mag), .den(d2_mag), .done(q2_done), .ovf(q2_ovf), .quo(q2)
    );

    assign sts.div_done = q1_done & q2_done;

    // integer part >= 2^30 means quotient >= 2^46
    logic        ovf1, ovf2, zero_det;
    logic signed [48:0] v1, v2, vsum, term;
    logic [SUM_W:0] added;

    assign ovf1     = q1_ovf;
    assign ovf2     = q2_ovf;
    assign zero_det = (det1_reg == '0) || (det2_reg == '0);
    assign v1 = (num_reg[48] ^ det1_reg[48]) ? -49'(q1) : 49'(q1);
    assign v2 = (num_reg[48] ^ det2_reg[48]) ? -49'(q2) : 49'(q2);
    assign vsum = v1 + v2 - 49'sd262144;
    assign term = vsum >>> 2;

    logic [SUM_W-1:0] sums_reg [CENTERS];
    logic             bad_reg;
    logic [SUM_W-1:0] cur_sum;

    assign cur_sum = sums_reg[cur_center];
    assign added   = {1'b0, cur_sum} + (SUM_W+1)'(term[47:0]);

    logic [CENTER_W-1:0] best_reg;
    logic [SUM_W-1:0]    bestd_reg;
    logic                strobe_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CENTERS; i++)
            begin
                sums_reg[i] <= '0;
            end
            bad_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.emit;
            if (cmd.accum && in_range)
            begin
                if (zero_det || ovf1 || ovf2)
                begin
                    sums_reg[cur_center] <= SUM_MAX;
                    bad_reg <= 1'b1;
                end
                else if (term > 49'sd0)
                begin
                    if (added[SUM_W])
                    begin
                        sums_reg[cur_center] <= SUM_MAX;
                        bad_reg <= 1'b1;
                    end
                    else
                    begin
                        sums_reg[cur_center] <= added[SUM_W-1:0];
                    end
                end
            end
            if (cmd.clear_step)
            begin
                sums_reg[cur_center] <= '0;
            end
            if (cmd.emit)
            begin
                bad_reg <= 1'b0;
            end
        end
    end

    logic deg_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pick_init)
        begin
            best_reg  <= '0;
            bestd_reg <= sums_reg[0];
        end
        else if (cmd.pick_step && (cur_sum < bestd_reg))
        begin
            best_reg  <= CENTER_W'(cur_center);
            bestd_reg <= cur_sum;
        end
        if (cmd.emit)
        begin
            deg_reg <= bad_reg;
        end
    end

    assign best_center   = best_reg;
    assign best_distance = bestd_reg;
    assign degenerate    = deg_reg;
    assign result_strobe = strobe_reg;

endmodule

/* hdl/tkl_ctrl.sv */
// Controller state machine: sequences loads, per-center KL terms, min search, clear.
// Uses tkl_pkg.
`timescale 1ns / 1ps

module tkl_ctrl
    import tkl_pkg::*;
#(
    parameter int CENTERS = CENTERS_DEF,
    parameter int SCALES  = SCALES_DEF,
    localparam int CIDX_W = (CENTERS > 1) ? $clog2(CENTERS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               req_type,
    input  logic [CENTER_W-1:0] center_sel,
    input  logic [SCALE_W-1:0] scale_sel,
    input  logic               last_scale,
    input  logic [ACT_W-1:0]   active_centers,
    input  tkl_sts_t           sts,
    output tkl_cmd_t           cmd,
    output logic [CIDX_W-1:0]  cur_center,
    output logic               in_range,
    output logic               busy
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_DET1  = 4'd2;
    localparam logic [3:0] ST_RD    = 4'd3;
    localparam logic [3:0] ST_WAIT  = 4'd4;
    localparam logic [3:0] ST_P1    = 4'd5;
    localparam logic [3:0] ST_P2    = 4'd6;
    localparam logic [3:0] ST_NUM   = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_ACC   = 4'd9;
    localparam logic [3:0] ST_PICK  = 4'd10;
    localparam logic [3:0] ST_EMIT  = 4'd11;
    localparam logic [3:0] ST_CLR   = 4'd12;
    localparam logic [3:0] ST_DW    = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [1:0]        elem_reg, elem_next;
    logic [CIDX_W-1:0] ctr_reg, ctr_next;
    logic              last_reg, last_next;
    logic              rng_reg, rng_next;
    logic [CIDX_W-1:0] n_last;   // index of last active center
    logic [6:0]        n_eff;
    logic              load_ok;

    always_comb
    begin
        if (active_centers == '0)
        begin
            n_eff = 7'd1;
        end
        else if (7'(active_centers) > 7'(CENTERS))
        begin
            n_eff = 7'(CENTERS);
        end
        else
        begin
            n_eff = 7'(active_centers);
        end
        n_last = CIDX_W'(n_eff - 7'd1);
        load_ok = (32'(center_sel) < CENTERS) && (32'(scale_sel) < SCALES);
    end

    always_comb
    begin
        state_next = state_reg;
        elem_next  = elem_reg;
        ctr_next   = ctr_reg;
        last_next  = last_reg;
        rng_next   = rng_reg;
        cmd        = '0;
        cmd.store_elem = elem_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    elem_next   = ELEM_A;
                    ctr_next    = '0;
                    last_next   = last_scale;
                    rng_next    = 32'(scale_sel) < SCALES;
                    if (req_type == REQ_LOAD)
                    begin
                        state_next = load_ok ? ST_LOAD : ST_IDLE;
                    end
                    else if (32'(scale_sel) < SCALES)
                    begin
                        state_next = ST_DET1;
                    end
                    else
                    begin
                        state_next = last_scale ? ST_PICK : ST_IDLE;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.store_we = 1'b1;
                elem_next = elem_reg + 2'd1;
                if (elem_reg == ELEM_C)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DET1:
            begin
                cmd.det_s  = 1'b1;
                elem_next  = ELEM_A;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.store_rd = 1'b1;
                elem_next = elem_reg + 2'd1;
                if (elem_reg == ELEM_C)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_P1;
            end
            ST_P1:
            begin
                cmd.prod_s1 = 1'b1;
                state_next  = ST_P2;
            end
            ST_P2:
            begin
                cmd.prod_s2 = 1'b1;
                state_next  = ST_NUM;
            end
            ST_NUM:
            begin
                state_next = ST_DW;
            end
            ST_DW:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                cmd.accum = 1'b1;
                elem_next = ELEM_A;
                if (ctr_reg == n_last)
                begin
                    ctr_next   = '0;
                    state_next = last_reg ? ST_PICK : ST_IDLE;
                end
                else
                begin
                    ctr_next   = ctr_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_PICK:
            begin
                // first cycle loads center zero, then walk the rest
                if (ctr_reg == '0)
                begin
                    cmd.pick_init = 1'b1;
                end
                else
                begin
                    cmd.pick_step = 1'b1;
                end
                if (ctr_reg == n_last)
                begin
                    ctr_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_CLR;
            end
            ST_CLR:
            begin
                cmd.clear_step = 1'b1;
                if (32'(ctr_reg) == CENTERS - 1)
                begin
                    ctr_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    ctr_next = ctr_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            elem_reg  <= '0;
            ctr_reg   <= '0;
            last_reg  <= 1'b0;
            rng_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            elem_reg  <= elem_next;
            ctr_reg   <= ctr_next;
            last_reg  <= last_next;
            rng_reg   <= rng_next;
        end
    end

    assign cur_center = ctr_reg;
    assign in_range   = rng_reg;
    assign busy       = (state_reg != ST_IDLE);

endmodule

/* hdl/tensor_kl_nearest_center.sv */
// Top level of the tensor KL nearest-center classifier.
// Uses tkl_pkg, tkl_ctrl, tkl_datapath; APB register for active_centers.
//
//  channel  | ports                                              | handshake
//  request  | req_type center_sel scale_sel tensor_a/b/c last_scale | start & !busy
//  result   | best_center best_distance degenerate               | done, one cycle
//  config   | psel penable pwrite paddr pwdata prdata pready     | APB, pready high
//
// A load holds busy while the three elements are written to the store. A classify
// holds busy for the det1 step and, per active center, the three store reads, a read
// wait, products, determinants and divider launch, the two bit-serial dividers (65
// steps plus done) running side by side, and an accumulate. A last classify adds a
// min-search step per active center, an emit step and a clear step for each of the
// CENTERS sums. Reset is asynchronous, clears the sums and flag, sets the register to 8.
// The receiver cannot stall; done marks each result for one cycle.
`timescale 1ns / 1ps

module tensor_kl_nearest_center
    import tkl_pkg::*;
#(
    parameter int CENTERS = CENTERS_DEF,
    parameter int SCALES  = SCALES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                req_type,
    input  logic [CENTER_W-1:0] center_sel,
    input  logic [SCALE_W-1:0]  scale_sel,
    input  logic signed [31:0]  tensor_a,
    input  logic signed [31:0]  tensor_b,
    input  logic signed [31:0]  tensor_c,
    input  logic                last_scale,
    output logic                done,
    output logic [CENTER_W-1:0] best_center,
    output logic [SUM_W-1:0]    best_distance,
    output logic                degenerate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [1:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int CIDX_W = (CENTERS > 1) ? $clog2(CENTERS) : 1;
    localparam logic [1:0] ADDR_ACTIVE = 2'd0;

    logic [ACT_W-1:0] active_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
        end
        else if (psel && penable && pwrite && paddr == ADDR_ACTIVE)
        begin
            active_reg <= pwdata[ACT_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_ACTIVE) ? 32'(active_reg) : 32'd0;

    tkl_cmd_t          cmd;
    tkl_sts_t          sts;
    logic [CIDX_W-1:0] cur_center;
    logic              in_range;

    tkl_ctrl #(.CENTERS(CENTERS), .SCALES(SCALES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .req_type(req_type),
        .center_sel(center_sel), .scale_sel(scale_sel), .last_scale(last_scale),
        .active_centers(active_reg), .sts(sts), .cmd(cmd),
        .cur_center(cur_center), .in_range(in_range), .busy(busy)
    );

    tkl_datapath #(.CENTERS(CENTERS), .SCALES(SCALES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .cur_center(cur_center), .in_range(in_range),
        .center_sel(center_sel), .scale_sel(scale_sel),
        .tensor_a(tensor_a), .tensor_b(tensor_b), .tensor_c(tensor_c),
        .best_center(best_center), .best_distance(best_distance),
        .degenerate(degenerate), .result_strobe(done)
    );

    // a result only follows an emit command
    a_done_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.emit))
        else $error("result without emit");

    // store is not written while the dividers are launched
    a_no_we_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !cmd.store_we)
        else $error("store write during divide");

    // controller is busy when it issues the emit command
    a_busy_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> busy)
        else $error("emit while idle");

endmodule
